[rtl/lfu_pkg.sv]
package lfu_pkg;

  // Field widths of one request and one result.
  localparam int KEY_W = 32;
  localparam int VAL_W = 31;
  localparam int CNT_W = 16;
  localparam int CFG_W = 5;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_W  = 64;
  localparam int OUT_W = 40;

  // Result bit positions inside m_axis_tdata.
  localparam int HIT_BIT = 0;
  localparam int RD_LSB  = 1;
  localparam int EV_BIT  = RD_LSB + VAL_W;

  // Use counts stop here.
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Capacity register value after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Request codes carried on s_axis_tuser.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } lfu_state_t;

endpackage

[rtl/lfu_cache_with_lru_tiebreak_unit.sv]
// Key-value cache with least-frequently-used replacement and a least-recently-used
// tie-break among entries of equal use count. One get or put is taken at a time: a
// transaction is accepted only in the idle state, then a sequencer sweeps the entry
// memories once to find the key, the first free slot and the victim, and, when the
// request changes state, sweeps them a second time to rewrite the recency ranks and
// the target entry. Each sweep reads one entry per cycle through one shared compare
// unit, so a request that changes the table runs both sweeps before the next possible
// acceptance, and a get miss or an ignored put runs only the first; either also waits
// while an earlier result is not yet taken. The result register lets a new request
// be accepted while the previous result still waits. The user must write the capacity
// register only while the block is idle; the block itself does not enforce this.
module lfu_cache_with_lru_tiebreak_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // Capacity register write port.
  input  logic                       cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_wr_data,
  // Request stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, from bit 0: lookup_key[31:0], store_value[62:32], zero pad[63].
  input  logic [lfu_pkg::IN_W-1:0]   s_axis_tdata,
  // tuser: cmd (0 get, 1 put).
  input  logic                       s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata, from bit 0: hit[0], read_value[31:1], evicted[32], zero pad[39:33].
  output logic [lfu_pkg::OUT_W-1:0]  m_axis_tdata
);

  import lfu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = IW;
  localparam int FW = (CW > CFG_W) ? CW : CFG_W;

  // Entry memories.
  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [CNT_W-1:0] cnt_mem  [CAPACITY];
  logic [RW-1:0]    rank_mem [CAPACITY];

  logic [CAPACITY-1:0] valid;
  logic [CW-1:0]       fill;
  logic [CFG_W-1:0]    capacity_in_use;
  lfu_state_t          st;

  // Sweep counter and read pipeline.
  logic [CW-1:0]    idx;
  logic [IW-1:0]    rd_addr;
  logic             p_vld;
  logic [IW-1:0]    p_idx;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0] rd_cnt;
  logic [RW-1:0]    rd_rank;

  // Request held for the whole operation.
  logic             req_cmd;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;

  // Scan findings.
  logic             found;
  logic [IW-1:0]    hit_idx;
  logic [VAL_W-1:0] hit_val;
  logic [CNT_W-1:0] hit_cnt;
  logic [RW-1:0]    hit_rank;
  logic             free_found;
  logic [IW-1:0]    free_idx;
  logic             have_vic;
  logic [IW-1:0]    vic_idx;
  logic [CNT_W-1:0] vic_cnt;
  logic [RW-1:0]    vic_rank;

  // Update plan.
  logic [IW-1:0]    tgt;
  logic [RW-1:0]    old_rank;
  logic             incr_all;
  logic [VAL_W-1:0] new_val;
  logic [CNT_W-1:0] new_cnt;

  // Result waiting to enter the output register.
  logic             res_hit;
  logic [VAL_W-1:0] res_rd;
  logic             res_ev;

  logic             sweep_last;
  logic             cur_valid;
  logic             key_match;
  logic             vic_better;
  logic [FW-1:0]    cap_eff;
  logic             ent_we;
  logic             rank_we;
  logic [RW-1:0]    rank_wd;
  logic             out_load;

  assign s_axis_tready = (st == S_IDLE);
  assign rd_addr       = idx[IW-1:0];
  assign sweep_last    = (idx == CW'(CAPACITY));
  assign cur_valid     = valid[p_idx];

  // Shared compare unit: key match and victim ordering for the entry just read.
  assign key_match  = cur_valid && (rd_key == req_key);
  assign vic_better = !have_vic || (rd_cnt < vic_cnt) ||
                      ((rd_cnt == vic_cnt) && (rd_rank > vic_rank));

  // Capacity in use, limited to the number of entries built.
  assign cap_eff = (FW'(capacity_in_use) > FW'(CAPACITY)) ? FW'(CAPACITY)
                                                           : FW'(capacity_in_use);

  // Second sweep writes: the target gets rank 0, others age as needed.
  assign ent_we  = (st == S_UPDATE) && p_vld && (p_idx == tgt);
  assign rank_we = ent_we ||
                   ((st == S_UPDATE) && p_vld && cur_valid &&
                    (incr_all || (rd_rank < old_rank)));
  assign rank_wd = ent_we ? '0 : rd_rank + RW'(1);

  assign out_load = (st == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Entry memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[p_idx] <= req_key;
      val_mem[p_idx] <= new_val;
      cnt_mem[p_idx] <= new_cnt;
    end
    if (rank_we) begin
      rank_mem[p_idx] <= rank_wd;
    end
    rd_key  <= key_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
    rd_cnt  <= cnt_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_in_use <= cfg_wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(OUT_W - EV_BIT - 1){1'b0}}, res_ev, res_rd, res_hit};
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      valid <= '0;
      fill  <= '0;
      p_vld <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          p_vld <= 1'b0;
          if (s_axis_tvalid) begin
            st <= S_SCAN;
          end
        end
        S_SCAN: begin
          p_vld <= !sweep_last;
          if (sweep_last) begin
            st <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          p_vld <= 1'b0;
          if (found) begin
            st <= S_UPDATE;
          end else if ((req_cmd == CMD_PUT) && (cap_eff != '0)) begin
            if (FW'(fill) < cap_eff) begin
              if (free_found) begin
                valid[free_idx] <= 1'b1;
                fill            <= fill + CW'(1);
                st              <= S_UPDATE;
              end else begin
                st <= S_DONE;
              end
            end else if (have_vic) begin
              st <= S_UPDATE;
            end else begin
              st <= S_DONE;
            end
          end else begin
            st <= S_DONE;
          end
        end
        S_UPDATE: begin
          p_vld <= !sweep_last;
          if (sweep_last) begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          p_vld <= 1'b0;
          if (!m_axis_tvalid || m_axis_tready) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st    <= S_IDLE;
          p_vld <= 1'b0;
        end
      endcase
    end
  end

  // Sequencer data path: request capture, scan findings and update plan.
  always_ff @(posedge clk) begin
    p_idx <= rd_addr;
    case (st)
      S_IDLE: begin
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
        have_vic   <= 1'b0;
        req_cmd    <= s_axis_tuser;
        req_key    <= s_axis_tdata[KEY_W-1:0];
        req_val    <= s_axis_tdata[KEY_W +: VAL_W];
      end
      S_SCAN: begin
        if (!sweep_last) begin
          idx <= idx + CW'(1);
        end
        if (p_vld) begin
          if (key_match && !found) begin
            found    <= 1'b1;
            hit_idx  <= p_idx;
            hit_val  <= rd_val;
            hit_cnt  <= rd_cnt;
            hit_rank <= rd_rank;
          end
          if (!cur_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= p_idx;
          end
          if (cur_valid && vic_better) begin
            have_vic <= 1'b1;
            vic_idx  <= p_idx;
            vic_cnt  <= rd_cnt;
            vic_rank <= rd_rank;
          end
        end
      end
      S_DECIDE: begin
        idx     <= '0;
        res_hit <= found;
        if (found) begin
          // Hit: bump the count and move the entry to most recent.
          res_ev   <= 1'b0;
          tgt      <= hit_idx;
          old_rank <= hit_rank;
          incr_all <= 1'b0;
          new_cnt  <= (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
          if (req_cmd == CMD_GET) begin
            res_rd  <= hit_val;
            new_val <= hit_val;
          end else begin
            res_rd  <= '0;
            new_val <= req_val;
          end
        end else if (FW'(fill) < cap_eff) begin
          // Fill a free slot: every valid entry ages by one.
          res_rd   <= '0;
          res_ev   <= 1'b0;
          tgt      <= free_idx;
          old_rank <= '0;
          incr_all <= 1'b1;
          new_cnt  <= CNT_W'(1);
          new_val  <= req_val;
        end else begin
          // Replace the victim.
          res_rd   <= '0;
          res_ev   <= (req_cmd == CMD_PUT) && (cap_eff != '0) && have_vic;
          tgt      <= vic_idx;
          old_rank <= vic_rank;
          incr_all <= 1'b0;
          new_cnt  <= CNT_W'(1);
          new_val  <= req_val;
        end
      end
      S_UPDATE: begin
        if (!sweep_last) begin
          idx <= idx + CW'(1);
        end
      end
      S_DONE: begin
        idx <= '0;
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule

[rtl/lfu_chk.sv]
module lfu_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lfu_pkg::OUT_W-1:0]  m_axis_tdata
);

  import lfu_pkg::*;

  // One request at a time: the block is busy right after an accepted transaction.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("request accepted while a request is in progress");

  // A result is never produced in the cycle right after acceptance.
  a_no_instant_result: assert property (
    @(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid)
  ) else $error("result appeared before the lookup sweep could finish");

  // A result waiting for the consumer is not dropped.
  a_result_holds: assert property (
    @(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata))
  ) else $error("pending result changed or vanished");

  // A hit never evicts, and a miss returns no value.
  a_result_consistent: assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!(m_axis_tdata[HIT_BIT] && m_axis_tdata[EV_BIT]) &&
                       (m_axis_tdata[HIT_BIT] || (m_axis_tdata[RD_LSB +: VAL_W] == '0)))
  ) else $error("inconsistent hit, evicted and read_value");

endmodule

bind lfu_cache_with_lru_tiebreak_unit lfu_chk u_lfu_chk (.*);

[tb/sv/lfu_cache_checker.sv]
module lfu_cache_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [lfu_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [lfu_pkg::OUT_W-1:0]  m_axis_tdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         hits_seen,
  output int                         evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } lookup_result_t;

  // Shadow copy of the cache table and its capacity register.
  logic             entry_valid [CAPACITY];
  logic [KEY_W-1:0] entry_key   [CAPACITY];
  logic [VAL_W-1:0] entry_value [CAPACITY];
  logic [CNT_W-1:0] use_count   [CAPACITY];
  logic [3:0]       recency     [CAPACITY];
  logic [CFG_W-1:0] fill_count;
  logic [CFG_W-1:0] capacity;

  // Results predicted for accepted requests, oldest first.
  lookup_result_t expected_results[$];

  task automatic clear_table();
    capacity   = CAP_RESET;
    fill_count = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_valid[i] = 1'b0;
      entry_key[i]   = '0;
      entry_value[i] = '0;
      use_count[i]   = '0;
      recency[i]     = '0;
    end
  endtask

  // Make one slot the most recent; entries that were more recent age by one.
  task automatic promote(input int slot);
    logic [3:0] old_rank;
    old_rank = recency[slot];
    for (int i = 0; i < CAPACITY; i++) begin
      if (entry_valid[i] && i != slot && recency[i] < old_rank) recency[i] = recency[i] + 1'b1;
    end
    recency[slot] = '0;
  endtask

  // Apply one get or put to the shadow table and return the result it must produce.
  task automatic predict_lookup(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, output lookup_result_t res);
    int               slot;
    int               free_slot;
    int               victim;
    logic [CFG_W-1:0] usable;
    res    = '0;
    usable = (capacity > CAPACITY) ? CFG_W'(CAPACITY) : capacity;
    slot   = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot < 0 && entry_valid[i] && entry_key[i] == key) slot = i;
    end

    if (slot >= 0) begin
      // Hit: a get reads, a put overwrites; both raise the count and the recency.
      res.hit = 1'b1;
      if (cmd == CMD_GET) res.read_value = entry_value[slot];
      else entry_value[slot] = value;
      if (use_count[slot] != COUNT_MAX) use_count[slot] = use_count[slot] + 1'b1;
      promote(slot);
    end else if (cmd == CMD_PUT && usable != 0) begin
      if (fill_count < usable) begin
        // Fill the lowest free slot as the most recent entry.
        free_slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (free_slot < 0 && !entry_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_valid[i]) recency[i] = recency[i] + 1'b1;
          end
          entry_valid[free_slot] = 1'b1;
          entry_key[free_slot]   = key;
          entry_value[free_slot] = value;
          use_count[free_slot]   = CNT_W'(1);
          recency[free_slot]     = '0;
          fill_count             = fill_count + 1'b1;
        end
      end else begin
        // Replace the least used entry, the least recent one among ties.
        victim = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_valid[i]) begin
            if (victim < 0 || use_count[i] < use_count[victim] ||
                (use_count[i] == use_count[victim] && recency[i] > recency[victim]))
              victim = i;
          end
        end
        if (victim >= 0) begin
          res.evicted         = 1'b1;
          entry_key[victim]   = key;
          entry_value[victim] = value;
          use_count[victim]   = CNT_W'(1);
          promote(victim);
        end
      end
    end
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (rst) begin
      clear_table();
      expected_results.delete();
      mismatches     = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    end else begin
      // Compare a result transaction with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit        = m_axis_tdata[HIT_BIT];
        got.read_value = m_axis_tdata[RD_LSB +: VAL_W];
        got.evicted    = m_axis_tdata[EV_BIT];
        hits_seen      = hits_seen + got.hit;
        evictions_seen = evictions_seen + got.evicted;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: hit %0b read_value 0x%08h evicted %0b",
                   $time, got.hit, got.read_value, got.evicted);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) begin
            mismatches++;
            $display("%0t: hit expected %0b, actual %0b", $time, want.hit, got.hit);
          end
          if (got.read_value !== want.read_value) begin
            mismatches++;
            $display("%0t: read_value expected 0x%08h, actual 0x%08h",
                     $time, want.read_value, got.read_value);
          end
          if (got.evicted !== want.evicted) begin
            mismatches++;
            $display("%0t: evicted expected %0b, actual %0b", $time, want.evicted, got.evicted);
          end
        end
      end

      if (cfg_wr_en) capacity = cfg_wr_data;

      // Predict the result of an accepted request transaction.
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lookup(s_axis_tuser, s_axis_tdata[0 +: KEY_W], s_axis_tdata[KEY_W +: VAL_W],
                       want);
        expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 136;
  localparam int POOL_SIZE       = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 2 * CAPACITY + 20;
  localparam int STALL_LIMIT     = 3000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;

  int mismatches;
  int outstanding;
  int hits_seen;
  int evictions_seen;

  // Stimulus controls shared with the receiver process.
  logic sender_idle      = 1'b1;
  logic receiver_idle    = 1'b1;
  logic hold_off_request = 1'b0;
  logic hold_off_done    = 1'b0;
  int   requests_sent    = 0;
  int   capacity_writes  = 0;
  int   idle_cycles      = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #6 clk = ~clk;

  lfu_cache_with_lru_tiebreak_unit #(.CAPACITY(CAPACITY)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lfu_cache_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  // Offer one request and hold it until the transaction completes.
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int gap;
    if (sender_idle && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_W - KEY_W - VAL_W){1'b0}}, value, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // The capacity register is only written once the block has gone idle.
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity_writes++;
  endtask

  // Mostly keys from a small pool so that hits, fills and evictions all happen.
  task automatic random_request(input int pool_n);
    logic             cmd;
    logic [KEY_W-1:0] key;
    cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
    key = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(pool_n - 1)];
    send_request(cmd, key, VAL_W'($urandom));
  endtask

  // Receiver: random back-pressure, or one long hold-off when asked for.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (receiver_idle) begin
        m_axis_tready <= ($urandom_range(99) >= 15);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles where neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    int          cap_plan [PHASES];
    int          usable;
    int          pool_n;
    cap_plan = '{16, 0, 1, 31, 16, 8, 2, 5, 16, 3, 12, 16};
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_GET;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, key and value extremes, get and put hits.
    send_request(CMD_GET, 32'h0000_0000, 31'h0);
    send_request(CMD_PUT, 32'h0000_0000, 31'h0);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(CMD_GET, 32'hFFFF_FFFF, 31'h0);
    send_request(CMD_GET, 32'h0000_0000, 31'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 31'h5555_5555);
    send_request(CMD_GET, 32'h0000_0000, 31'h0);
    send_request(CMD_GET, 32'h1234_5678, 31'h0);

    // Zero capacity: a put miss is dropped, hits still work.
    write_capacity(5'd0);
    send_request(CMD_PUT, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
    send_request(CMD_GET, 32'hAAAA_AAAA, 31'h0);
    send_request(CMD_GET, 32'h0000_0000, 31'h0);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 31'h1);

    // Capacity below the fill: a put miss replaces the least used entry.
    write_capacity(5'd1);
    send_request(CMD_PUT, 32'h1357_9BDF, 31'h0246_8ACE);
    send_request(CMD_GET, 32'hFFFF_FFFF, 31'h0);
    send_request(CMD_GET, 32'h1357_9BDF, 31'h0);

    // Capacity above the table size counts as a full table.
    write_capacity(5'd31);
    send_request(CMD_PUT, 32'h8000_0000, 31'h4000_0000);
    send_request(CMD_PUT, 32'h0000_0001, 31'h0000_0001);
    send_request(CMD_GET, 32'h8000_0000, 31'h0);
    send_request(CMD_PUT, 32'h0000_0001, 31'h7FFF_FFFE);

    // Random phases, one capacity setting each.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p][CFG_W-1:0]);
      sender_idle   = (p != 1);
      receiver_idle = (p != 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
        if ($urandom_range(9) < 3) key_pool[i] = $urandom;
      end
      usable = (cap_plan[p] > CAPACITY) ? CAPACITY : cap_plan[p];
      pool_n = usable + $urandom_range(2, 8);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == 20) hold_off_request = 1'b1;
        if (p == 6 && n == 60) drain_results();
        random_request(pool_n);
      end
    end

    // Let the last results arrive and the block settle.
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests across %0d capacity settings, including zero and oversize.",
             requests_sent, capacity_writes);
    $display("Results seen: %0d hits, %0d evictions; %0d still pending.",
             hits_seen, evictions_seen, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
